### sv/tpsm_pkg.sv
`default_nettype none
package tpsm_pkg;
    localparam int unsigned InWidth  = 60;
    localparam int unsigned OutWidth = 50;
    localparam int unsigned ModWidth = 50;
    localparam logic [ModWidth-1:0] Modulus = 50'd1000000000000007;

    typedef logic [ModWidth-1:0] t_res;
    typedef t_res t_mat [16];

    // companion matrix, row major
    function automatic t_res f_companion(input logic [3:0] idx);
        t_res v;
        v = '0;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd9, 4'd14: v = t_res'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // add two residues, result stays reduced
    function automatic t_res f_add_mod(input t_res a, input t_res b);
        logic [ModWidth:0] s;
        logic [ModWidth:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, Modulus};
        return d[ModWidth] ? s[ModWidth-1:0] : d[ModWidth-1:0];
    endfunction
endpackage
`default_nettype wire

### sv/tribonacci_prefix_sum_modpow_top.sv
`default_nettype none
// The work is up to 119 matrix products (60 exponent bits) of 64 serial modular products each,
// then a dot product of four serial modular products for the sum.
// Counts up to 3 strobe in the cycle after the start; a new word is taken only once that strobe has gone.
// Throughput: one word at a time; busy is high from the accepting edge through the strobe.
// Reset (synchronous, active low) returns the sequencer to idle.
// The receiver cannot stall: the result is on o_prefix_sum for one cycle with o_done.
module tribonacci_prefix_sum_modpow_top
    import tpsm_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [InWidth-1:0]  i_term_count,
    output logic                     o_done,
    output logic [OutWidth-1:0]      o_prefix_sum
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_WAIT = 5'b00100,
        S_NEXT = 5'b01000,
        S_DOT  = 5'b10000
    } t_state;

    t_state r_state;
    t_mat   r_base;
    t_mat   r_acc;
    t_mat   r_tmp;
    logic [InWidth-1:0] r_exp;
    logic   r_sq;          // current pass: 0 acc*=base, 1 base*=base
    logic [1:0] r_i;
    logic [1:0] r_j;
    logic [1:0] r_k;
    t_res   r_sum;
    logic   r_mstart;
    logic   r_done;
    t_res   r_out;

    t_res   op_a;
    t_res   op_b;
    t_res   seed;
    logic   m_done;
    t_res   m_prod;
    t_res   acc_new;

    // dot pass reuses k over row 0 of acc against the seed vector
    always_comb begin
        case (r_k)
            2'd0: seed = t_res'(6);
            2'd1: seed = t_res'(3);
            2'd2: seed = t_res'(2);
            default: seed = t_res'(1);
        endcase
        if (r_state == S_DOT) begin
            op_a = r_acc[{2'd0, r_k}];
            op_b = seed;
        end else if (r_sq) begin
            op_a = r_base[{r_i, r_k}];
            op_b = r_base[{r_k, r_j}];
        end else begin
            op_a = r_acc[{r_i, r_k}];
            op_b = r_base[{r_k, r_j}];
        end
        acc_new = f_add_mod(r_sum, m_prod);
    end

    tpsm_modmul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_done  (m_done),
        .o_prod  (m_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mstart <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_mstart <= 1'b0;
                    // take a word only once the previous strobe has gone out
                    if (start && !busy) begin
                        for (int q = 0; q < 16; q++) begin
                            r_base[q] <= f_companion(4'(q));
                            r_acc[q]  <= (q % 5 == 0) ? t_res'(1) : '0;
                        end
                        r_i <= '0;
                        r_j <= '0;
                        r_k <= '0;
                        r_sum <= '0;
                        if (i_term_count <= InWidth'(3)) begin
                            case (i_term_count[1:0])
                                2'd1: r_out <= t_res'(1);
                                2'd2: r_out <= t_res'(3);
                                2'd3: r_out <= t_res'(6);
                                default: r_out <= '0;
                            endcase
                            r_done <= 1'b1;
                        end else begin
                            r_exp <= i_term_count - InWidth'(3);
                            r_sq  <= ~(i_term_count[0] ^ 1'b1); // exp bit0 = ~n[0]
                            r_state <= S_NEXT;
                            r_done <= 1'b0;
                        end
                    end else begin
                        r_done <= 1'b0;
                    end
                end
                S_NEXT: begin
                    // pick the next pass or finish
                    r_done <= 1'b0;
                    r_mstart <= 1'b1;
                    r_i <= '0;
                    r_j <= '0;
                    r_k <= '0;
                    r_sum <= '0;
                    if (r_exp == '0) begin
                        r_state <= S_DOT;
                    end else begin
                        r_sq  <= !r_exp[0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_done <= 1'b0;
                    if (m_done) begin
                        if (r_k == 2'd3) begin
                            r_tmp[{r_i, r_j}] <= acc_new;
                            r_sum <= '0;
                            if ({r_i, r_j} == 4'hF) begin
                                r_state <= S_WAIT;
                                r_mstart <= 1'b0;
                            end else begin
                                {r_i, r_j} <= {r_i, r_j} + 4'd1;
                                r_mstart <= 1'b1;
                            end
                        end else begin
                            r_sum <= acc_new;
                            r_mstart <= 1'b1;
                        end
                        r_k <= r_k + 2'd1;
                    end else begin
                        r_mstart <= 1'b0;
                    end
                end
                S_WAIT: begin
                    // commit the product; shift the exponent after squaring, clear its bit 0 otherwise
                    r_done <= 1'b0;
                    r_mstart <= 1'b0;
                    if (r_sq) begin
                        r_base <= r_tmp;
                        r_exp  <= r_exp >> 1;
                    end else begin
                        r_acc <= r_tmp;
                        r_exp <= {r_exp[InWidth-1:1], 1'b0};
                    end
                    r_state <= S_NEXT;
                end
                S_DOT: begin
                    if (m_done) begin
                        r_sum <= acc_new;
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_out <= acc_new;
                            r_done <= 1'b1;
                            r_mstart <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_done <= 1'b0;
                            r_mstart <= 1'b1;
                        end
                    end else begin
                        r_done <= 1'b0;
                        r_mstart <= 1'b0;
                    end
                end
                default: begin
                    r_done <= 1'b0;
                    r_mstart <= 1'b0;
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (r_state != S_IDLE) || r_done;
    assign o_done       = r_done;
    assign o_prefix_sum = OutWidth'(r_out);
endmodule
`default_nettype wire

### sv/tpsm_modmul.sv
`default_nettype none
// Serial modular multiplier: one bit of b per cycle, MSB first.
module tpsm_modmul
    import tpsm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_start,
    input  wire t_res i_a,
    input  wire t_res i_b,
    output logic      o_done,
    output t_res      o_prod
);
    logic [5:0] r_cnt;
    logic [5:0] n_cnt;
    logic       r_run;
    logic       n_run;
    t_res       r_acc;
    t_res       n_acc;
    t_res       r_a;
    t_res       r_b;
    t_res       dbl;

    always_comb begin
        dbl   = f_add_mod(r_acc, r_acc);
        n_acc = r_acc;
        n_cnt = r_cnt;
        n_run = r_run;
        if (i_start) begin
            n_acc = '0;
            n_cnt = 6'(ModWidth);
            n_run = 1'b1;
        end else if (r_run) begin
            n_acc = r_b[r_cnt[5:0] - 6'd1] ? f_add_mod(dbl, r_a) : dbl;
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_run = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_run <= n_run;
            r_cnt <= n_cnt;
        end
        r_acc <= n_acc;
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
    end

    assign o_done = r_run && (r_cnt == 6'd1);
    assign o_prod = n_acc;
endmodule
`default_nettype wire

### verif/tribonacci_prefix_sum_modpow_top_test.sv
`timescale 1ns / 100ps
`default_nettype none
module tribonacci_prefix_sum_modpow_top_test;
    import tpsm_pkg::*;

    typedef logic [InWidth-1:0] t_count;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_count             i_term_count;
    logic               o_done;
    logic [OutWidth-1:0] o_prefix_sum;

    // expected sums, oldest first
    logic [OutWidth-1:0] pending_sums[$];
    int unsigned         mismatches;
    int unsigned         sender_idle_pct;

    tribonacci_prefix_sum_modpow_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_term_count (i_term_count),
        .o_done       (o_done),
        .o_prefix_sum (o_prefix_sum)
    );

    always #5 i_clk = ~i_clk;

    // Multiply two residues and reduce; the full product fits in twice the width.
    function automatic t_res mul_residue(input t_res a, input t_res b);
        logic [2*ModWidth-1:0] prod;
        prod = {{ModWidth{1'b0}}, a} * {{ModWidth{1'b0}}, b};
        return t_res'(prod % {{ModWidth{1'b0}}, Modulus});
    endfunction

    function automatic t_mat mat_product(input t_mat p, input t_mat q);
        t_mat r;
        t_res acc;
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                acc = '0;
                for (int k = 0; k < 4; k++) begin
                    acc = f_add_mod(acc, mul_residue(p[i*4+k], q[k*4+j]));
                end
                r[i*4+j] = acc;
            end
        end
        return r;
    endfunction

    // Sum of the first n tribonacci terms, modulo the package modulus.
    function automatic logic [OutWidth-1:0] tribonacci_prefix(input t_count n);
        t_mat step;
        t_mat acc;
        t_count e;
        logic [ModWidth+3:0] dot;
        if (n == 0) return '0;
        if (n == 1) return OutWidth'(1);
        if (n == 2) return OutWidth'(3);
        if (n == 3) return OutWidth'(6);
        for (int i = 0; i < 16; i++) begin
            step[i] = (i == 0 || i == 1 || i == 2 || i == 3 || i == 5 || i == 6
                       || i == 7 || i == 9 || i == 14) ? t_res'(1) : t_res'(0);
            acc[i]  = (i % 5 == 0) ? t_res'(1) : t_res'(0);
        end
        e = n - t_count'(3);
        while (e != 0) begin
            if (e[0]) acc = mat_product(acc, step);
            e = e >> 1;
            if (e != 0) step = mat_product(step, step);
        end
        // dot row 0 with the seed vector (6,3,2,1)
        dot = 6 * acc[0] + 3 * acc[1] + 2 * acc[2] + acc[3];
        return OutWidth'(dot % Modulus);
    endfunction

    // Present one word and hold start until the block takes it.
    task automatic send_count(input t_count n);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_term_count <= n;
        do @(posedge i_clk); while (busy);
        pending_sums = {pending_sums, tribonacci_prefix(n)};
    endtask

    // Drop start and wait for every expected sum to come back.
    task automatic drain;
        start <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Compare each strobed result with the oldest expected sum.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_sums.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %0d", o_prefix_sum);
            end else begin
                if (o_prefix_sum !== pending_sums[0]) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("prefix_sum mismatch: expected %0d, got %0d",
                                 pending_sums[0], o_prefix_sum);
                end
                void'(pending_sums.pop_front());
            end
        end
    end

    // Zero, the three direct answers and the first matrix cases.
    task automatic test_short_counts;
        sender_idle_pct = 0;
        for (int n = 0; n <= 9; n++) send_count(t_count'(n));
        drain();
    endtask

    // Widest counts: all ones, top bit alone, alternating bit patterns, and a large decimal count.
    task automatic test_wide_counts;
        send_count('1);
        send_count(t_count'(1) << (InWidth - 1));
        send_count({(InWidth/2){2'b01}});
        send_count({(InWidth/2){2'b10}});
        send_count(t_count'(64'd1000000000000000000));
        drain();
    endtask

    // Mostly small counts so the serial multiplier stays quick, some medium,
    // and rarely a full-width count.
    task automatic test_random_traffic(input int unsigned idle_pct, input int items);
        t_count n;
        int unsigned pick;
        sender_idle_pct = idle_pct;
        for (int i = 0; i < items; i++) begin
            pick = $urandom_range(99);
            if (pick < 85)
                n = t_count'($urandom_range(0, 24));
            else if (pick < 99)
                n = t_count'($urandom_range(25, 4000));
            else
                n = t_count'({$urandom, $urandom});
            send_count(n);
        end
        drain();
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_term_count    = '0;
        mismatches      = 0;
        sender_idle_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_short_counts();
        test_wide_counts();
        test_random_traffic(22, 95);
        test_random_traffic(66, 95);
        test_random_traffic(0, 95);

        if (mismatches == 0 && pending_sums.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // hard stop for a hung block
    initial begin
        #400_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
